@@ rtl/mfba_pkg.sv @@
// ----------------------------------------------------------------------------
// mfba_pkg
// Shared sizes and constants of the max flow (BFS augmenting path) unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mfba_pkg;

  localparam int unsigned NODE_COUNT = 2048;
  localparam int unsigned EDGE_SLOTS = 16384;

  localparam int unsigned NODE_W  = $clog2(NODE_COUNT);
  localparam int unsigned EDGE_W  = $clog2(EDGE_SLOTS);
  localparam int unsigned LINK_W  = EDGE_W + 1;
  localparam int unsigned CNT_W   = EDGE_W + 1;
  localparam int unsigned QPTR_W  = NODE_W + 1;
  localparam int unsigned CAP_W   = 31;

  localparam logic [LINK_W-1:0] NIL_LINK = '1;
  localparam logic [CAP_W-1:0]  CAP_MAX  = '1;
  localparam logic [CNT_W:0]    SLOTS_LIMIT = (CNT_W+1)'(EDGE_SLOTS);

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_RUN = 1'b1;

endpackage : mfba_pkg

`default_nettype wire

@@ rtl/max_flow_bfs_augment_unit.sv @@
// ----------------------------------------------------------------------------
// max_flow_bfs_augment_unit
// Edge store plus Edmonds-Karp maximum flow sequencer over on-chip memories.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one command per
//   transaction. An add command stores a forward edge and its zero-capacity
//   reverse partner (with fewer than two free slots it sets the drop flag);
//   a stored add keeps the block busy in S_ADD0 to S_ADD3 and returns nothing.
//   A run command computes the max flow from source_node_i to sink_node_i and
//   returns one transaction on the output channel (out_valid_o / out_stall_i)
//   with the saturated total_flow_o and the sticky edges_dropped_o flag.
//   After acceptance a run repeats a breadth-first search, a sweep clearing
//   its marks and, if the sink was reached, a path bottleneck and update walk;
//   the result is valid the cycle after the last, failed search ends. A run
//   with source equal to sink is valid the cycle after acceptance.
//   The block holds one command at a time: in_stall_o is high while a
//   command is in work, or while a result waits on a stalled receiver.
//   After reset, a pass over all node entries clears the node list heads and
//   visit marks; in_stall_o stays high until it ends.
//   Under output stall the result register holds its transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module max_flow_bfs_augment_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         cmd_i,
  input  wire logic [mfba_pkg::NODE_W-1:0]  from_node_i,
  input  wire logic [mfba_pkg::NODE_W-1:0]  to_node_i,
  input  wire logic [mfba_pkg::CAP_W-1:0]   capacity_i,
  input  wire logic [mfba_pkg::NODE_W-1:0]  source_node_i,
  input  wire logic [mfba_pkg::NODE_W-1:0]  sink_node_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [mfba_pkg::CAP_W-1:0]        total_flow_o,
  output logic                              edges_dropped_o
);

  localparam int unsigned NW = mfba_pkg::NODE_W;
  localparam int unsigned EW = mfba_pkg::EDGE_W;
  localparam int unsigned LW = mfba_pkg::LINK_W;
  localparam int unsigned CW = mfba_pkg::CAP_W;
  localparam int unsigned QW = mfba_pkg::QPTR_W;

  localparam logic [4:0] S_CLR  = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_ADD0 = 5'd2;
  localparam logic [4:0] S_ADD1 = 5'd3;
  localparam logic [4:0] S_ADD2 = 5'd4;
  localparam logic [4:0] S_ADD3 = 5'd5;
  localparam logic [4:0] S_INIT = 5'd6;
  localparam logic [4:0] S_DEQ  = 5'd7;
  localparam logic [4:0] S_DEQ2 = 5'd8;
  localparam logic [4:0] S_FRST = 5'd9;
  localparam logic [4:0] S_EDG  = 5'd10;
  localparam logic [4:0] S_EDG2 = 5'd11;
  localparam logic [4:0] S_EDG3 = 5'd12;
  localparam logic [4:0] S_CHK  = 5'd13;
  localparam logic [4:0] S_CHK2 = 5'd14;
  localparam logic [4:0] S_SWA  = 5'd15;
  localparam logic [4:0] S_SWB  = 5'd16;
  localparam logic [4:0] S_MIN0 = 5'd17;
  localparam logic [4:0] S_MIN1 = 5'd18;
  localparam logic [4:0] S_MIN2 = 5'd19;
  localparam logic [4:0] S_UPD0 = 5'd20;
  localparam logic [4:0] S_UPD1 = 5'd21;
  localparam logic [4:0] S_UPD2 = 5'd22;
  localparam logic [4:0] S_UPD3 = 5'd23;

  // memories
  logic [NW-1:0] head_mem   [mfba_pkg::EDGE_SLOTS];
  logic [CW-1:0] res_mem    [mfba_pkg::EDGE_SLOTS];
  logic [LW-1:0] link_mem   [mfba_pkg::EDGE_SLOTS];
  logic [LW-1:0] first_mem  [mfba_pkg::NODE_COUNT];
  logic [LW-1:0] last_mem   [mfba_pkg::NODE_COUNT];
  logic          seen_mem   [mfba_pkg::NODE_COUNT];
  logic [NW-1:0] parent_mem [mfba_pkg::NODE_COUNT];
  logic [EW-1:0] pedge_mem  [mfba_pkg::NODE_COUNT];
  logic [NW-1:0] queue_mem  [mfba_pkg::NODE_COUNT];

  logic          head_we, head_re, res_we, res_re, link_we, link_re;
  logic [EW-1:0] head_wa, head_ra, res_wa, res_ra, link_wa, link_ra;
  logic [NW-1:0] head_wd;
  logic [CW-1:0] res_wd;
  logic [LW-1:0] link_wd;
  logic [NW-1:0] head_rd_q;
  logic [CW-1:0] res_rd_q;
  logic [LW-1:0] link_rd_q;

  logic          first_we, first_re, last_we, last_re;
  logic [NW-1:0] first_wa, first_ra, last_wa, last_ra;
  logic [LW-1:0] first_wd, last_wd, first_rd_q, last_rd_q;

  logic          seen_we, seen_re, seen_wd, seen_rd_q;
  logic [NW-1:0] seen_wa, seen_ra;

  logic          par_we, par_re;
  logic [NW-1:0] par_wa, par_ra, par_wd, par_rd_q;
  logic [EW-1:0] pedge_wd, pedge_rd_q;

  logic          queue_we, queue_re;
  logic [NW-1:0] queue_wa, queue_ra, queue_wd, queue_rd_q;

  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    if (head_re) head_rd_q <= head_mem[head_ra];
    if (res_we) res_mem[res_wa] <= res_wd;
    if (res_re) res_rd_q <= res_mem[res_ra];
    if (link_we) link_mem[link_wa] <= link_wd;
    if (link_re) link_rd_q <= link_mem[link_ra];
    if (first_we) first_mem[first_wa] <= first_wd;
    if (first_re) first_rd_q <= first_mem[first_ra];
    if (last_we) last_mem[last_wa] <= last_wd;
    if (last_re) last_rd_q <= last_mem[last_ra];
    if (seen_we) seen_mem[seen_wa] <= seen_wd;
    if (seen_re) seen_rd_q <= seen_mem[seen_ra];
    if (par_we) begin
      parent_mem[par_wa] <= par_wd;
      pedge_mem[par_wa]  <= pedge_wd;
    end
    if (par_re) begin
      par_rd_q   <= parent_mem[par_ra];
      pedge_rd_q <= pedge_mem[par_ra];
    end
    if (queue_we) queue_mem[queue_wa] <= queue_wd;
    if (queue_re) queue_rd_q <= queue_mem[queue_ra];
  end

  // control registers
  logic [4:0]                   state_q, state_d;
  logic [QW-1:0]                cnt_q, cnt_d;
  logic [QW-1:0]                qtail_q, qtail_d;
  logic [mfba_pkg::CNT_W-1:0]   ecount_q, ecount_d;
  logic                         ovf_q, ovf_d;
  logic                         found_q, found_d;
  logic                         out_valid_q, out_valid_d;
  logic [CW-1:0]                out_flow_q, out_flow_d;
  logic                         out_drop_q, out_drop_d;
  // payload registers
  logic [NW-1:0] src_q, src_d, snk_q, snk_d, from_q, from_d, to_q, to_d;
  logic [CW-1:0] cap_q, cap_d;
  logic [NW-1:0] here_q, here_d, p_q, p_d, pn_q, pn_d;
  logic [LW-1:0] e_q, e_d;
  logic [EW-1:0] ev_q, ev_d;
  logic [CW-1:0] amt_q, amt_d, total_q, total_d;

  logic          accept;
  logic [EW-1:0] f_idx, r_idx;
  logic [CW:0]   total_sum;

  assign in_stall_o      = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign accept          = in_valid_i && !in_stall_o;
  assign f_idx           = ecount_q[EW-1:0];
  assign r_idx           = f_idx | EW'(1);
  assign total_sum       = {1'b0, total_q} + {1'b0, amt_q};
  assign out_valid_o     = out_valid_q;
  assign total_flow_o    = out_flow_q;
  assign edges_dropped_o = out_drop_q;

  always_comb begin
    state_d = state_q;  cnt_d = cnt_q;  qtail_d = qtail_q;
    ecount_d = ecount_q;  ovf_d = ovf_q;  found_d = found_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_flow_d = out_flow_q;  out_drop_d = out_drop_q;
    src_d = src_q;  snk_d = snk_q;  from_d = from_q;  to_d = to_q;  cap_d = cap_q;
    here_d = here_q;  p_d = p_q;  pn_d = pn_q;  e_d = e_q;  ev_d = ev_q;
    amt_d = amt_q;  total_d = total_q;

    head_we = 1'b0;  head_wa = f_idx;  head_wd = to_q;  head_re = 1'b0;
    head_ra = e_q[EW-1:0];
    res_we = 1'b0;  res_wa = f_idx;  res_wd = cap_q;  res_re = 1'b0;
    res_ra = e_q[EW-1:0];
    link_we = 1'b0;  link_wa = f_idx;  link_wd = mfba_pkg::NIL_LINK;
    link_re = 1'b0;  link_ra = e_q[EW-1:0];
    first_we = 1'b0;  first_wa = from_q;  first_wd = {1'b0, f_idx};
    first_re = 1'b0;  first_ra = here_d;
    last_we = 1'b0;  last_wa = from_q;  last_wd = {1'b0, f_idx};
    last_re = 1'b0;  last_ra = from_q;
    seen_we = 1'b0;  seen_wa = head_rd_q;  seen_wd = 1'b1;
    seen_re = 1'b0;  seen_ra = head_rd_q;
    par_we = 1'b0;  par_wa = head_rd_q;  par_wd = here_q;  pedge_wd = e_q[EW-1:0];
    par_re = 1'b0;  par_ra = p_q;
    queue_we = 1'b0;  queue_wa = qtail_q[NW-1:0];  queue_wd = head_rd_q;
    queue_re = 1'b0;  queue_ra = cnt_q[NW-1:0];

    case (state_q)
      S_CLR: begin
        first_we = 1'b1;  first_wa = cnt_q[NW-1:0];  first_wd = mfba_pkg::NIL_LINK;
        last_we  = 1'b1;  last_wa  = cnt_q[NW-1:0];  last_wd  = mfba_pkg::NIL_LINK;
        seen_we  = 1'b1;  seen_wa  = cnt_q[NW-1:0];  seen_wd  = 1'b0;
        cnt_d = cnt_q + QW'(1);
        if (cnt_q[NW-1:0] == '1) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          from_d = from_node_i;  to_d = to_node_i;  cap_d = capacity_i;
          src_d = source_node_i;  snk_d = sink_node_i;
          if (cmd_i == mfba_pkg::CMD_ADD) begin
            if (({1'b0, ecount_q} + 2'd2) > mfba_pkg::SLOTS_LIMIT) ovf_d = 1'b1;
            else state_d = S_ADD0;
          end else if (source_node_i == sink_node_i) begin
            out_valid_d = 1'b1;  out_flow_d = '0;  out_drop_d = ovf_q;
          end else begin
            total_d = '0;
            state_d = S_INIT;
          end
        end
      end
      S_ADD0: begin
        head_we = 1'b1;  res_we = 1'b1;  link_we = 1'b1;
        last_re = 1'b1;  last_ra = from_q;
        state_d = S_ADD1;
      end
      S_ADD1: begin
        if (last_rd_q == mfba_pkg::NIL_LINK) first_we = 1'b1;
        else begin
          link_we = 1'b1;  link_wa = last_rd_q[EW-1:0];  link_wd = {1'b0, f_idx};
        end
        last_we = 1'b1;
        state_d = S_ADD2;
      end
      S_ADD2: begin
        head_we = 1'b1;  head_wa = r_idx;  head_wd = from_q;
        res_we = 1'b1;  res_wa = r_idx;  res_wd = '0;
        link_we = 1'b1;  link_wa = r_idx;
        last_re = 1'b1;  last_ra = to_q;
        state_d = S_ADD3;
      end
      S_ADD3: begin
        first_wa = to_q;  first_wd = {1'b0, r_idx};
        if (last_rd_q == mfba_pkg::NIL_LINK) first_we = 1'b1;
        else begin
          link_we = 1'b1;  link_wa = last_rd_q[EW-1:0];  link_wd = {1'b0, r_idx};
        end
        last_we = 1'b1;  last_wa = to_q;  last_wd = {1'b0, r_idx};
        ecount_d = ecount_q + mfba_pkg::CNT_W'(2);
        state_d = S_IDLE;
      end
      S_INIT: begin
        seen_we = 1'b1;  seen_wa = src_q;
        queue_we = 1'b1;  queue_wa = '0;  queue_wd = src_q;
        cnt_d = '0;  qtail_d = QW'(1);
        state_d = S_DEQ;
      end
      S_DEQ: begin
        if (cnt_q == qtail_q) state_d = S_CHK;
        else begin
          queue_re = 1'b1;
          cnt_d = cnt_q + QW'(1);
          state_d = S_DEQ2;
        end
      end
      S_DEQ2: begin
        here_d = queue_rd_q;
        first_re = 1'b1;  first_ra = queue_rd_q;
        state_d = S_FRST;
      end
      S_FRST: begin
        e_d = first_rd_q;
        state_d = S_EDG;
      end
      S_EDG: begin
        if (e_q == mfba_pkg::NIL_LINK) state_d = S_DEQ;
        else begin
          head_re = 1'b1;  res_re = 1'b1;  link_re = 1'b1;
          state_d = S_EDG2;
        end
      end
      S_EDG2: begin
        seen_re = 1'b1;
        state_d = S_EDG3;
      end
      S_EDG3: begin
        if ((res_rd_q != '0) && !seen_rd_q) begin
          seen_we = 1'b1;  par_we = 1'b1;  queue_we = 1'b1;
          qtail_d = qtail_q + QW'(1);
        end
        e_d = link_rd_q;
        state_d = S_EDG;
      end
      S_CHK: begin
        seen_re = 1'b1;  seen_ra = snk_q;
        state_d = S_CHK2;
      end
      S_CHK2: begin
        found_d = seen_rd_q;
        cnt_d = '0;
        state_d = S_SWA;
      end
      S_SWA: begin
        if (cnt_q == qtail_q) begin
          if (found_q) begin
            p_d = snk_q;  amt_d = mfba_pkg::CAP_MAX;
            state_d = S_MIN0;
          end else begin
            out_valid_d = 1'b1;  out_flow_d = total_q;  out_drop_d = ovf_q;
            state_d = S_IDLE;
          end
        end else begin
          queue_re = 1'b1;
          state_d = S_SWB;
        end
      end
      S_SWB: begin
        seen_we = 1'b1;  seen_wa = queue_rd_q;  seen_wd = 1'b0;
        cnt_d = cnt_q + QW'(1);
        state_d = S_SWA;
      end
      S_MIN0: begin
        if (p_q == src_q) begin
          p_d = snk_q;
          state_d = S_UPD0;
        end else begin
          par_re = 1'b1;
          state_d = S_MIN1;
        end
      end
      S_MIN1: begin
        res_re = 1'b1;  res_ra = pedge_rd_q;
        pn_d = par_rd_q;
        state_d = S_MIN2;
      end
      S_MIN2: begin
        if (res_rd_q < amt_q) amt_d = res_rd_q;
        p_d = pn_q;
        state_d = S_MIN0;
      end
      S_UPD0: begin
        if (p_q == src_q) begin
          total_d = total_sum[CW] ? mfba_pkg::CAP_MAX : total_sum[CW-1:0];
          state_d = S_INIT;
        end else begin
          par_re = 1'b1;
          state_d = S_UPD1;
        end
      end
      S_UPD1: begin
        res_re = 1'b1;  res_ra = pedge_rd_q;
        ev_d = pedge_rd_q;  pn_d = par_rd_q;
        state_d = S_UPD2;
      end
      S_UPD2: begin
        res_we = 1'b1;  res_wa = ev_q;  res_wd = res_rd_q - amt_q;
        res_re = 1'b1;  res_ra = ev_q ^ EW'(1);
        state_d = S_UPD3;
      end
      S_UPD3: begin
        res_we = 1'b1;  res_wa = ev_q ^ EW'(1);  res_wd = res_rd_q + amt_q;
        p_d = pn_q;
        state_d = S_UPD0;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      cnt_q       <= '0;
      qtail_q     <= '0;
      ecount_q    <= '0;
      ovf_q       <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      qtail_q     <= qtail_d;
      ecount_q    <= ecount_d;
      ovf_q       <= ovf_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_flow_q <= out_flow_d;
    out_drop_q <= out_drop_d;
    src_q      <= src_d;
    snk_q      <= snk_d;
    from_q     <= from_d;
    to_q       <= to_d;
    cap_q      <= cap_d;
    here_q     <= here_d;
    p_q        <= p_d;
    pn_q       <= pn_d;
    e_q        <= e_d;
    ev_q       <= ev_d;
    amt_q      <= amt_d;
    total_q    <= total_d;
  end

endmodule : max_flow_bfs_augment_unit

`default_nettype wire
